>>> rtl/idwm_pkg.sv
`default_nettype none

package idwm_pkg;

  // Defaults for the top-level parameters
  localparam int RELIEF_DIV_DEF        = 4;
  localparam int WINDOW_COUNT_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TICKS       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BUDGET_CYCLES      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CYCLES_PER_US      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STALL_WINDOW_LIMIT = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_RELIEF_ENABLE      = 3'd4;

  // Register reset values
  localparam logic [15:0] WINDOW_TICKS_RST       = 16'd400;
  localparam logic [31:0] BUDGET_CYCLES_RST      = 32'd24000;
  localparam logic [12:0] CYCLES_PER_US_RST      = 13'd1;
  localparam logic [7:0]  STALL_WINDOW_LIMIT_RST = 8'd3;

  // Divisor width of the shared divider (tick counts and cycles per us fit)
  localparam int DEN_W = 32;

  localparam int          PERCENT_SCALE = 100;
  localparam logic [7:0]  STALL_MAX     = 8'd255;

  typedef struct packed {
    logic [31:0] isr_cycles;
    logic [31:0] enc_cycles;
    logic        enc_measured;
    logic [31:0] loop_cycles;
    logic [31:0] main_heartbeat;
  } tick_t;

  typedef struct packed {
    logic        skip_control;
    logic        over_budget;
    logic [31:0] isr_us_now;
    logic [31:0] isr_us_peak;
    logic [31:0] overrun_total;
    logic        window_done;
    logic [31:0] win_isr_us_max;
    logic [31:0] win_enc_us_max;
    logic [31:0] win_loop_us_max;
    logic [6:0]  win_over_percent;
    logic        keeper_request;
    logic        relief_active;
  } report_t;

endpackage

`default_nettype wire

>>> rtl/idwm_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. done pulses for one cycle
// with the quotient on quot.
module idwm_div #(
  parameter int NW = 32,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quot
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [NW-1:0]    q;
  logic [DW:0]      trial;
  logic             ge;

  // Shift in the next numerator bit and try a subtract
  always_comb begin
    trial = {rem, q[NW-1]};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NW);
        q    <= num;
        rem  <= '0;
        dvs  <= den;
      end else if (busy) begin
        q   <= {q[NW-2:0], ge};
        rem <= ge ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;

endmodule

`default_nettype wire

>>> rtl/isr_deadline_window_monitor.sv
`default_nettype none

// Handler timing monitor. Each tick transfer carries the handler, encoder and
// loop cycle counts and the main-loop heartbeat; one report transfer follows
// per tick. All cycle-to-microsecond conversions and the overrun percentage
// run through one shared restoring divider of NW = max(32, WINDOW_COUNT_BITS
// + 7) bits, one quotient bit per cycle. A tick that does not close a window
// needs one division and a tick that closes a window needs five; all of
// them end before the next tick transfer can be taken. tick_stall is high
// while a tick is being worked on. A finished report waits in the output
// register without holding up the next tick transfer; if it is still waiting
// when the following report is ready, that report is held back and
// tick_stall stays high until the register is taken.
// Configuration writes are meant for times when no tick is in flight.
module isr_deadline_window_monitor #(
  parameter int RELIEF_DIV        = idwm_pkg::RELIEF_DIV_DEF,
  parameter int WINDOW_COUNT_BITS = idwm_pkg::WINDOW_COUNT_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [idwm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [idwm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                             tick_valid,
  output logic                                  tick_stall,
  input  wire idwm_pkg::tick_t                  tick,
  output logic                                  report_valid,
  input  wire logic                             report_stall,
  output idwm_pkg::report_t                     report
);

  localparam int W       = WINDOW_COUNT_BITS;
  localparam int PHASE_W = $clog2(RELIEF_DIV);
  localparam int NW      = (W + 7 > 32) ? W + 7 : 32;
  localparam int DW      = idwm_pkg::DEN_W;

  typedef enum logic [2:0] {
    S_IDLE, S_NOW, S_ISR, S_ENC, S_LOOP, S_PCT, S_OUT
  } state_t;

  // Configuration registers
  logic [15:0] window_ticks;
  logic [31:0] budget_cycles;
  logic [12:0] cycles_per_us;
  logic [7:0]  stall_window_limit;
  logic        relief_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks       <= idwm_pkg::WINDOW_TICKS_RST;
      budget_cycles      <= idwm_pkg::BUDGET_CYCLES_RST;
      cycles_per_us      <= idwm_pkg::CYCLES_PER_US_RST;
      stall_window_limit <= idwm_pkg::STALL_WINDOW_LIMIT_RST;
      relief_enable      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        idwm_pkg::REG_WINDOW_TICKS:       window_ticks       <= cfg_data[15:0];
        idwm_pkg::REG_BUDGET_CYCLES:      budget_cycles      <= cfg_data[31:0];
        idwm_pkg::REG_CYCLES_PER_US:      cycles_per_us      <= cfg_data[12:0];
        idwm_pkg::REG_STALL_WINDOW_LIMIT: stall_window_limit <= cfg_data[7:0];
        idwm_pkg::REG_RELIEF_ENABLE:      relief_enable      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Monitor state
  state_t             state;
  logic [W-1:0]       win_count;
  logic [W-1:0]       win_overruns;
  logic [31:0]        win_isr_peak;
  logic [31:0]        win_enc_peak;
  logic [31:0]        win_loop_peak;
  logic [31:0]        last_heartbeat;
  logic [7:0]         stalled_windows;
  logic               relief_mode;
  logic [PHASE_W-1:0] tick_phase;
  logic [31:0]        lifetime_us_peak;
  logic [31:0]        lifetime_overruns;

  // Window snapshot kept for the close-time divisions
  logic               closing;
  logic [31:0]        snap_isr;
  logic [31:0]        snap_enc;
  logic [31:0]        snap_loop;
  logic [W-1:0]       snap_ovr;
  logic [W-1:0]       snap_cnt;
  idwm_pkg::report_t  res;

  // Shared divider
  logic          div_start;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic          div_done;
  logic [NW-1:0] div_quot;

  idwm_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quot (div_quot)
  );

  // Per-tick update of the window and stall state
  logic [W-1:0]       wmax;
  logic [PHASE_W-1:0] phase_upd;
  logic               skip;
  logic               over;
  logic [31:0]        enc_upd;
  logic [31:0]        loop_upd;
  logic [31:0]        isr_upd;
  logic [W-1:0]       cnt_upd;
  logic [W-1:0]       ovr_upd;
  logic               close;
  logic               hb_moved;
  logic [7:0]         stalled_upd;
  logic               relief_upd;
  logic [12:0]        per;
  logic [31:0]        quot32;
  logic               tick_xfer;
  idwm_pkg::report_t  res_start;

  always_comb begin
    wmax      = '1;
    phase_upd = (tick_phase == PHASE_W'(RELIEF_DIV - 1)) ? '0 : tick_phase + PHASE_W'(1);
    skip      = relief_mode && relief_enable && (phase_upd == '0);
    over      = tick.isr_cycles > budget_cycles;
    enc_upd   = (tick.enc_measured && tick.enc_cycles > win_enc_peak) ?
                tick.enc_cycles : win_enc_peak;
    loop_upd  = (!skip && tick.loop_cycles > win_loop_peak) ?
                tick.loop_cycles : win_loop_peak;
    isr_upd   = (tick.isr_cycles > win_isr_peak) ? tick.isr_cycles : win_isr_peak;
    cnt_upd   = (win_count < wmax) ? win_count + W'(1) : win_count;
    ovr_upd   = (over && win_overruns < wmax) ? win_overruns + W'(1) : win_overruns;
    close     = (33'(cnt_upd) >= 33'(window_ticks)) || (cnt_upd == wmax);
    hb_moved  = tick.main_heartbeat != last_heartbeat;
    stalled_upd = (stalled_windows < idwm_pkg::STALL_MAX) ?
                  stalled_windows + 8'd1 : stalled_windows;
    relief_upd = relief_mode;
    if (close) begin
      if (hb_moved) begin
        relief_upd = 1'b0;
      end else if (relief_enable && stalled_upd >= stall_window_limit) begin
        relief_upd = 1'b1;
      end
    end
    per       = (cycles_per_us == '0) ? 13'd1 : cycles_per_us;
    quot32    = div_quot[31:0];
    tick_xfer = tick_valid && !tick_stall;

    // report fields known at the tick transfer; divisions fill in the rest
    res_start                = '0;
    res_start.skip_control   = skip;
    res_start.over_budget    = over;
    res_start.overrun_total  = lifetime_overruns + 32'(over);
    res_start.window_done    = close;
    res_start.keeper_request = close && !hb_moved;
    res_start.relief_active  = relief_upd;
  end

  assign tick_stall = (state != S_IDLE);

  // Sequencer, monitor state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      win_count         <= '0;
      win_overruns      <= '0;
      win_isr_peak      <= '0;
      win_enc_peak      <= '0;
      win_loop_peak     <= '0;
      last_heartbeat    <= '0;
      stalled_windows   <= '0;
      relief_mode       <= 1'b0;
      tick_phase        <= '0;
      lifetime_us_peak  <= '0;
      lifetime_overruns <= '0;
      div_start         <= 1'b0;
      report_valid      <= 1'b0;
    end else begin
      div_start <= 1'b0;
      // S_OUT sets valid itself when it loads the register
      if (report_valid && !report_stall && state != S_OUT) begin
        report_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tick_xfer) begin
            tick_phase        <= phase_upd;
            lifetime_overruns <= lifetime_overruns + 32'(over);
            closing           <= close;
            snap_isr          <= isr_upd;
            snap_enc          <= enc_upd;
            snap_loop         <= loop_upd;
            snap_ovr          <= ovr_upd;
            snap_cnt          <= cnt_upd;
            res               <= res_start;
            relief_mode       <= relief_upd;

            if (close) begin
              win_count     <= '0;
              win_overruns  <= '0;
              win_isr_peak  <= '0;
              win_enc_peak  <= '0;
              win_loop_peak <= '0;
              if (hb_moved) begin
                last_heartbeat  <= tick.main_heartbeat;
                stalled_windows <= '0;
              end else begin
                stalled_windows <= stalled_upd;
              end
            end else begin
              win_count     <= cnt_upd;
              win_overruns  <= ovr_upd;
              win_isr_peak  <= isr_upd;
              win_enc_peak  <= enc_upd;
              win_loop_peak <= loop_upd;
            end

            div_num   <= NW'(tick.isr_cycles);
            div_den   <= DW'(per);
            div_start <= 1'b1;
            state     <= S_NOW;
          end
        end
        S_NOW: begin
          if (div_done) begin
            res.isr_us_now <= quot32;
            if (quot32 > lifetime_us_peak) begin
              lifetime_us_peak <= quot32;
              res.isr_us_peak  <= quot32;
            end else begin
              res.isr_us_peak  <= lifetime_us_peak;
            end
            if (closing) begin
              div_num   <= NW'(snap_isr);
              div_start <= 1'b1;
              state     <= S_ISR;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_ISR: begin
          if (div_done) begin
            res.win_isr_us_max <= quot32;
            div_num   <= NW'(snap_enc);
            div_start <= 1'b1;
            state     <= S_ENC;
          end
        end
        S_ENC: begin
          if (div_done) begin
            res.win_enc_us_max <= quot32;
            div_num   <= NW'(snap_loop);
            div_start <= 1'b1;
            state     <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (div_done) begin
            res.win_loop_us_max <= quot32;
            div_num   <= NW'(snap_ovr) * NW'(idwm_pkg::PERCENT_SCALE);
            div_den   <= DW'(snap_cnt);
            div_start <= 1'b1;
            state     <= S_PCT;
          end
        end
        S_PCT: begin
          if (div_done) begin
            res.win_over_percent <= div_quot[6:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!report_valid || !report_stall) begin
            report       <= res;
            report_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks

  // The divider only finishes while the sequencer waits on it
  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_NOW || state == S_ISR || state == S_ENC ||
                  state == S_LOOP || state == S_PCT))
    else $error("divider finished outside a division step");

  // Window fields stay zero on a report that did not close a window
  a_open_window_zero: assert property (@(posedge clk) disable iff (rst)
    (report_valid && !report.window_done) |->
      (report.win_over_percent == 7'd0 && !report.keeper_request &&
       report.win_isr_us_max == 32'd0))
    else $error("window fields set on a report without a window close");

  // Overrun share never tops one hundred percent
  a_percent_range: assert property (@(posedge clk) disable iff (rst)
    report_valid |-> (report.win_over_percent <= 7'd100))
    else $error("overrun percentage out of range");

endmodule

`default_nettype wire
